FILE: sv/dsd_pkg.sv
// Shared types and constants for the deck shuffle-and-deal block.
package dsd_pkg;

   localparam int FUNC_W   = 2;
   localparam int RND_W    = 32;
   localparam int CODE_W   = 6;
   localparam int LEFT_W   = 7;
   localparam int STEP_W   = $clog2(RND_W);

   localparam logic [FUNC_W-1:0] FUNC_NEW  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SWAP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEAL = 2'd2;

   typedef enum logic [1:0] {
      OP_NEW,
      OP_SWAP,
      OP_DEAL,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [RND_W-1:0] rnd;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

FILE: sv/dsd_front.sv
// Request intake: decodes the operation and queues requests for the back end.
module dsd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [dsd_pkg::FUNC_W-1:0] req_func,
   input  logic [dsd_pkg::RND_W-1:0]  req_rnd,
   input  logic                      pop,
   output dsd_pkg::head_type         head
);

   dsd_pkg::entry_type q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   dsd_pkg::entry_type new_entry;
   logic               push;
   logic               do_pop;

   always_comb begin
      unique case (req_func)
         dsd_pkg::FUNC_NEW:  new_entry.op = dsd_pkg::OP_NEW;
         dsd_pkg::FUNC_SWAP: new_entry.op = dsd_pkg::OP_SWAP;
         dsd_pkg::FUNC_DEAL: new_entry.op = dsd_pkg::OP_DEAL;
         default:            new_entry.op = dsd_pkg::OP_NOP;
      endcase
      new_entry.rnd = req_rnd;
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign do_pop     = pop && (count_ff != 2'd0);
   assign wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in  = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in   = count_ff + {1'b0, push} - {1'b0, do_pop};

   assign head.valid = (count_ff != 2'd0);
   assign head.entry = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: sv/dsd_back.sv
// Execution engine: deck memory, bit-serial remainder, swap and deal sequencing.
module dsd_back #(
   parameter int CARD_COUNT = 52
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dsd_pkg::head_type          head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [dsd_pkg::CODE_W-1:0] rsp_card_code,
   output logic                       rsp_card_valid,
   output logic                       rsp_shuffle_done,
   output logic [dsd_pkg::LEFT_W-1:0] rsp_cards_left
);

   localparam int IW = $clog2(CARD_COUNT);
   localparam int CW = $clog2(CARD_COUNT + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_READ,
      S_WRITE_I,
      S_WRITE_J,
      S_DEAL_RD,
      S_RESP
   } state_type;

   state_type                   state_ff, state_in;
   logic [IW-1:0]               swap_ff, swap_in;
   logic [CW-1:0]               deal_ff, deal_in;
   logic [CARD_COUNT-1:0]       vld_ff, vld_in;
   logic [dsd_pkg::RND_W-1:0]   rnd_ff, rnd_in;
   logic [IW-1:0]               rem_ff, rem_in;
   logic [dsd_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic                        vi_ff, vi_in;
   logic                        vj_ff, vj_in;
   logic [dsd_pkg::CODE_W-1:0]  tmp_ff, tmp_in;
   logic [IW-1:0]               addr_ff, addr_in;
   logic [dsd_pkg::CODE_W-1:0]  code_ff, code_in;
   logic                        cvalid_ff, cvalid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dsd_pkg::CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic                        rsp_cvalid_ff, rsp_cvalid_in;
   logic                        rsp_done_ff, rsp_done_in;
   logic [dsd_pkg::LEFT_W-1:0]  rsp_left_ff, rsp_left_in;

   logic [dsd_pkg::CODE_W-1:0]  deck_mem [CARD_COUNT];
   logic [dsd_pkg::CODE_W-1:0]  rd0_ff, rd1_ff;
   logic                        we;
   logic [IW-1:0]               wa, ra0, ra1;
   logic [dsd_pkg::CODE_W-1:0]  wd;

   logic [IW:0]                 divisor;
   logic [IW:0]                 trial;
   logic [IW-1:0]               deal_idx;
   logic [dsd_pkg::CODE_W-1:0]  val_i, val_j;

   assign divisor  = {1'b0, swap_ff} + {{IW{1'b0}}, 1'b1};
   assign trial    = {rem_ff, rnd_ff[dsd_pkg::RND_W-1]};
   assign deal_idx = deal_ff[IW-1:0];
   assign val_i    = vi_ff ? rd0_ff : dsd_pkg::CODE_W'(swap_ff);
   assign val_j    = vj_ff ? rd1_ff : dsd_pkg::CODE_W'(rem_ff);

   always_comb begin
      state_in      = state_ff;
      swap_in       = swap_ff;
      deal_in       = deal_ff;
      vld_in        = vld_ff;
      rnd_in        = rnd_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      vi_in         = vi_ff;
      vj_in         = vj_ff;
      tmp_in        = tmp_ff;
      addr_in       = addr_ff;
      code_in       = code_ff;
      cvalid_in     = cvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_code_in   = rsp_code_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_left_in   = rsp_left_ff;
      pop           = 1'b0;
      we            = 1'b0;
      wa            = swap_ff;
      wd            = val_j;
      ra0           = swap_ff;
      ra1           = rem_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               code_in   = '0;
               cvalid_in = 1'b0;
               state_in  = S_RESP;
               case (head.entry.op)
                  dsd_pkg::OP_NEW: begin
                     vld_in  = '0;
                     swap_in = IW'(CARD_COUNT - 1);
                     deal_in = '0;
                  end
                  dsd_pkg::OP_SWAP: begin
                     if (swap_ff != '0) begin
                        rnd_in   = head.entry.rnd;
                        rem_in   = '0;
                        cnt_in   = '1;
                        state_in = S_DIV;
                     end
                  end
                  dsd_pkg::OP_DEAL: begin
                     if (deal_ff < CW'(CARD_COUNT)) begin
                        ra0      = deal_idx;
                        vi_in    = vld_ff[deal_idx];
                        addr_in  = deal_idx;
                        deal_in  = deal_ff + CW'(1);
                        state_in = S_DEAL_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (trial >= divisor) begin
               rem_in = IW'(trial - divisor);
            end else begin
               rem_in = trial[IW-1:0];
            end
            rnd_in = rnd_ff << 1;
            cnt_in = cnt_ff - dsd_pkg::STEP_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            vi_in    = vld_ff[swap_ff];
            vj_in    = vld_ff[rem_ff];
            state_in = S_WRITE_I;
         end
         S_WRITE_I: begin
            we              = 1'b1;
            wa              = swap_ff;
            wd              = val_j;
            tmp_in          = val_i;
            vld_in[swap_ff] = 1'b1;
            state_in        = S_WRITE_J;
         end
         S_WRITE_J: begin
            we             = 1'b1;
            wa             = rem_ff;
            wd             = tmp_ff;
            vld_in[rem_ff] = 1'b1;
            swap_in        = swap_ff - IW'(1);
            deal_in        = '0;
            code_in        = '0;
            cvalid_in      = 1'b0;
            state_in       = S_RESP;
         end
         S_DEAL_RD: begin
            code_in   = vi_ff ? rd0_ff : dsd_pkg::CODE_W'(addr_ff);
            cvalid_in = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = code_ff;
               rsp_cvalid_in = cvalid_ff;
               rsp_done_in   = (swap_ff == '0);
               rsp_left_in   = dsd_pkg::LEFT_W'(CARD_COUNT) - dsd_pkg::LEFT_W'(deal_ff);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         swap_ff      <= IW'(CARD_COUNT - 1);
         deal_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         swap_ff      <= swap_in;
         deal_ff      <= deal_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rnd_ff        <= rnd_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      vi_ff         <= vi_in;
      vj_ff         <= vj_in;
      tmp_ff        <= tmp_in;
      addr_ff       <= addr_in;
      code_ff       <= code_in;
      cvalid_ff     <= cvalid_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_left_ff   <= rsp_left_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         deck_mem[wa] <= wd;
      end
      rd0_ff <= deck_mem[ra0];
      rd1_ff <= deck_mem[ra1];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_card_code    = rsp_code_ff;
   assign rsp_card_valid   = rsp_cvalid_ff;
   assign rsp_shuffle_done = rsp_done_ff;
   assign rsp_cards_left   = rsp_left_ff;

endmodule

FILE: sv/deck_shuffle_deal_core.sv
// Deck shuffle-and-deal core: top level joining request intake and execution engine.
//
// Request channel (req_valid/req_ready, req_func, req_rnd): new ordered deck,
// one Fisher-Yates swap step using req_rnd, or deal of the next card.
// Response channel (rsp_valid/rsp_ready): one response per request with the
// dealt card, shuffle status and the number of cards still to deal.
// Requests enter a two-entry queue, so intake continues while the engine works.
// Response paths: a new deck, an unused code, a deal from an empty deck or a swap
// after the shuffle is done goes straight to the response stage. Otherwise a deal
// first reads the deck memory, and a swap step first forms the bit-serial remainder
// of req_rnd by the swap position plus one, followed by a dual-port read and two
// single-port writes of the deck memory. The engine runs one request at a time and
// pops the next one only after the previous response enters the output register.
// Reset restores the ordered deck at once (per-card valid bits), sets the
// swap position to the last card and the deal position to zero.
// A stalled receiver holds the response in the output register; the engine
// finishes its next request and waits, and the queue fills before req_ready drops.
module deck_shuffle_deal_core #(
   parameter int CARD_COUNT = 52
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [dsd_pkg::FUNC_W-1:0] req_func,
   input  logic [dsd_pkg::RND_W-1:0]  req_rnd,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [dsd_pkg::CODE_W-1:0] rsp_card_code,
   output logic                       rsp_card_valid,
   output logic                       rsp_shuffle_done,
   output logic [dsd_pkg::LEFT_W-1:0] rsp_cards_left
);

   dsd_pkg::head_type head;
   logic              pop;

   dsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_rnd   (req_rnd),
      .pop       (pop),
      .head      (head)
   );

   dsd_back #(
      .CARD_COUNT (CARD_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_card_code    (rsp_card_code),
      .rsp_card_valid   (rsp_card_valid),
      .rsp_shuffle_done (rsp_shuffle_done),
      .rsp_cards_left   (rsp_cards_left)
   );

endmodule

FILE: sv/dsd_checker.sv
// Port-level checks for the deck shuffle-and-deal core, with bind.
module dsd_checker #(
   parameter int CARD_COUNT = 52
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [dsd_pkg::CODE_W-1:0] rsp_card_code,
   input logic                       rsp_card_valid,
   input logic                       rsp_shuffle_done,
   input logic [dsd_pkg::LEFT_W-1:0] rsp_cards_left
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_card_code)
         && $stable(rsp_card_valid) && $stable(rsp_shuffle_done)
         && $stable(rsp_cards_left))
      else $error("response changed while stalled");

   a_no_card_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_card_valid |-> rsp_card_code == '0)
      else $error("card code nonzero without a dealt card");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cards_left <= dsd_pkg::LEFT_W'(CARD_COUNT))
      else $error("cards left out of range");

   a_deal_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_card_valid |->
         rsp_cards_left < dsd_pkg::LEFT_W'(CARD_COUNT)
         && rsp_card_code <= dsd_pkg::CODE_W'(CARD_COUNT - 1))
      else $error("dealt card inconsistent with deck size");

endmodule

bind deck_shuffle_deal_core dsd_checker #(.CARD_COUNT(CARD_COUNT)) u_dsd_checker (.*);
